// ===== sv/stpc_pkg.sv =====
// shared types and constants for the stepper target position controller
`default_nettype none

package stpc_pkg;

  // field widths
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned TGT_W    = 10;
  localparam int unsigned POS_W    = 16;
  localparam int unsigned COIL_W   = 4;
  localparam int unsigned PHASE_W  = 2;
  localparam int unsigned CFG_IX_W = 1;
  localparam int unsigned CFG_W    = 16;

  // configuration reset values
  localparam logic [POS_W-1:0] TARGET_INCREMENT_RST = 16'd1000;
  localparam logic [POS_W-1:0] MAX_POSITION_RST     = 16'd4096;

  // configuration register indexes
  localparam logic [CFG_IX_W-1:0] CFG_TARGET_INCREMENT = 1'b0;
  localparam logic [CFG_IX_W-1:0] CFG_MAX_POSITION     = 1'b1;

  // item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_TICK       = 3'd0,
    KIND_RIGHT      = 3'd1,
    KIND_LEFT       = 3'd2,
    KIND_STOP       = 3'd3,
    KIND_CALIBRATE  = 3'd4,
    KIND_SET_TARGET = 3'd5
  } kind_t;

endpackage

`default_nettype wire

// ===== sv/stepper_target_position_controller_core.sv =====
// Stepper target position controller: input register, update logic, result register.
// Path: an item transfers into the input register, then moves on to the state/result
// register, where its result is offered; one compare, add and saturate lie between
// the two.
// Throughput: one item per cycle while out_stall is low; the input register takes a new
// item while a result waits; stall reaches upstream only when both registers are full.
// Reset (rst_n low, synchronous): position, target, phase, mode, direction and
// coils clear, increment returns to 1000 and max position to 4096.
`default_nettype none

module stepper_target_position_controller_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration
  input  wire logic                              cfg_we,
  input  wire logic [stpc_pkg::CFG_IX_W-1:0]     cfg_index,
  input  wire logic [stpc_pkg::CFG_W-1:0]        cfg_wdata,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [stpc_pkg::KIND_W-1:0]       in_kind,
  input  wire logic [stpc_pkg::TGT_W-1:0]        in_new_target,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [stpc_pkg::COIL_W-1:0]            out_coil_drive,
  output logic [stpc_pkg::POS_W-1:0]             out_position_now,
  output logic [stpc_pkg::POS_W-1:0]             out_target_now,
  output logic                                   out_is_running,
  output logic                                   out_turning_ccw
);

  localparam logic [stpc_pkg::POS_W-1:0] POS_MAX = '1;

  // configuration registers
  logic [stpc_pkg::POS_W-1:0] inc_r;
  logic [stpc_pkg::POS_W-1:0] max_pos_r;

  // input register
  logic                        in_vld_r;
  logic [stpc_pkg::KIND_W-1:0] kind_r;
  logic [stpc_pkg::TGT_W-1:0]  new_tgt_r;

  // controller state, also the result payload
  logic                          out_vld_r;
  logic [stpc_pkg::POS_W-1:0]    position_r, position_nxt;
  logic [stpc_pkg::POS_W-1:0]    goal_r, goal_nxt;
  logic [stpc_pkg::PHASE_W-1:0]  phase_r, phase_nxt;
  logic                          running_r, running_nxt;
  logic                          ccw_r, ccw_nxt;
  logic [stpc_pkg::COIL_W-1:0]   coils_r, coils_nxt;

  logic advance;
  logic in_xfer;

  // step datapath
  logic                          step_ccw;
  logic [stpc_pkg::COIL_W-1:0]   step_coils;
  logic [stpc_pkg::PHASE_W-1:0]  step_phase;
  logic [stpc_pkg::POS_W-1:0]    step_pos;
  logic [stpc_pkg::POS_W:0]      goal_sum;
  logic                          pos_lt, pos_gt, pos_eq, pos_lim;
  logic                          steer_ccw;

  // handshake: the input register moves on when the result register is free
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign in_xfer  = in_valid && !in_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_r     <= stpc_pkg::TARGET_INCREMENT_RST;
      max_pos_r <= stpc_pkg::MAX_POSITION_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        stpc_pkg::CFG_TARGET_INCREMENT: inc_r     <= cfg_wdata;
        stpc_pkg::CFG_MAX_POSITION:     max_pos_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_xfer) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind_r    <= in_kind;
      new_tgt_r <= in_new_target;
    end
  end

  // steering compares
  assign pos_lt    = position_r < goal_r;
  assign pos_gt    = position_r > goal_r;
  assign pos_eq    = position_r == goal_r;
  assign pos_lim   = (position_r == '0) || (position_r >= max_pos_r);
  assign steer_ccw = pos_gt ? 1'b1 : (pos_lt ? 1'b0 : ccw_r);

  // one full step in the chosen direction
  always_comb begin
    case (stpc_pkg::kind_t'(kind_r))
      stpc_pkg::KIND_RIGHT: step_ccw = 1'b0;
      stpc_pkg::KIND_LEFT:  step_ccw = 1'b1;
      default:              step_ccw = steer_ccw;
    endcase
  end

  assign step_coils = stpc_pkg::COIL_W'(1) << phase_r;
  assign step_phase = step_ccw ? phase_r - 1'b1 : phase_r + 1'b1;
  assign step_pos   = step_ccw ? ((position_r == '0) ? position_r : position_r - 1'b1)
                               : ((position_r == POS_MAX) ? position_r : position_r + 1'b1);
  assign goal_sum   = {1'b0, goal_r} + {1'b0, inc_r};

  // next state for the item in the input register
  always_comb begin
    position_nxt = position_r;
    goal_nxt     = goal_r;
    phase_nxt    = phase_r;
    running_nxt  = running_r;
    ccw_nxt      = ccw_r;
    coils_nxt    = coils_r;
    case (stpc_pkg::kind_t'(kind_r))
      stpc_pkg::KIND_TICK: begin
        if (running_r) begin
          ccw_nxt = steer_ccw;
          if (pos_eq) begin
            running_nxt = 1'b0;
            coils_nxt   = '0;
          end else if (pos_lim) begin
            running_nxt = 1'b0;
          end else begin
            coils_nxt    = step_coils;
            phase_nxt    = step_phase;
            position_nxt = step_pos;
          end
        end
      end
      stpc_pkg::KIND_RIGHT: begin
        ccw_nxt      = 1'b0;
        running_nxt  = 1'b1;
        coils_nxt    = step_coils;
        phase_nxt    = step_phase;
        position_nxt = step_pos;
        goal_nxt     = goal_sum[stpc_pkg::POS_W] ? POS_MAX : goal_sum[stpc_pkg::POS_W-1:0];
      end
      stpc_pkg::KIND_LEFT: begin
        ccw_nxt      = 1'b1;
        phase_nxt    = step_phase;
        position_nxt = step_pos;
        if (goal_r >= inc_r) begin
          running_nxt = 1'b1;
          coils_nxt   = step_coils;
          goal_nxt    = goal_r - inc_r;
        end else begin
          // target would go below zero: hold at the new position
          running_nxt = 1'b0;
          coils_nxt   = '0;
          goal_nxt    = step_pos;
        end
      end
      stpc_pkg::KIND_STOP: begin
        running_nxt = 1'b0;
        goal_nxt    = position_r;
        coils_nxt   = '0;
      end
      stpc_pkg::KIND_CALIBRATE: begin
        position_nxt = '0;
        goal_nxt     = '0;
      end
      stpc_pkg::KIND_SET_TARGET: begin
        running_nxt = 1'b1;
        goal_nxt    = stpc_pkg::POS_W'(new_tgt_r);
      end
      default: ;
    endcase
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      position_r <= '0;
      goal_r     <= '0;
      phase_r    <= '0;
      running_r  <= 1'b0;
      ccw_r      <= 1'b0;
      coils_r    <= '0;
    end else begin
      if (advance) begin
        out_vld_r  <= 1'b1;
        position_r <= position_nxt;
        goal_r     <= goal_nxt;
        phase_r    <= phase_nxt;
        running_r  <= running_nxt;
        ccw_r      <= ccw_nxt;
        coils_r    <= coils_nxt;
      end else if (!out_stall) begin
        out_vld_r  <= 1'b0;
      end
    end
  end

  // result ports
  assign out_valid        = out_vld_r;
  assign out_coil_drive   = coils_r;
  assign out_position_now = position_r;
  assign out_target_now   = goal_r;
  assign out_is_running   = running_r;
  assign out_turning_ccw  = ccw_r;

`ifndef SYNTH
  // coils carry at most one energized phase
  a_coils_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(coils_r))
    else $error("more than one coil driven");

  // a tick while stopped leaves position and coils alone
  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && kind_r == stpc_pkg::KIND_TICK && !running_r)
      |=> ($stable(position_r) && $stable(coils_r) && !running_r))
    else $error("tick moved a stopped motor");

  // stop parks the target on the position
  a_stop_parks: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && kind_r == stpc_pkg::KIND_STOP)
      |=> (!running_r && goal_r == position_r && coils_r == '0))
    else $error("stop did not park");

  // a held result keeps the state registers frozen
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_stall)
      |=> ($stable(position_r) && $stable(goal_r) && $stable(phase_r)))
    else $error("state changed under a stalled result");

  // a pending item waits in the input register while the result is stalled
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && out_vld_r && out_stall) |=> (in_vld_r && $stable(kind_r)))
    else $error("pending item lost");
`endif

endmodule

`default_nettype wire

// ===== sim/stepper_target_position_controller_core_tb.sv =====
// self-checking testbench for the stepper target position controller core
`timescale 1ns / 100ps

module stepper_target_position_controller_core_tb;
  import stpc_pkg::*;

  // kinds the block must ignore
  localparam logic [KIND_W-1:0] KIND_RSVD_6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_RSVD_7 = 3'd7;
  localparam logic [POS_W-1:0]  POS_TOP     = 16'hFFFF;
  localparam int unsigned       PHASES      = 6;
  localparam int unsigned       PHASE_ITEMS = 225;
  localparam int unsigned       HOLD_CYCLES = 80;

  typedef struct packed {
    logic [COIL_W-1:0] coil;
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  tgt;
    logic              run;
    logic              ccw;
  } motor_res_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TGT_W-1:0]  tgt;
    logic              typed;
    motor_res_t        res;
  } plan_row_t;

  localparam motor_res_t NO_CHECK = '0;

  // directed opening: typed rows are read straight off the spec, the rest use the predictor
  localparam plan_row_t DIRECTED_PLAN [0:24] = '{
    '{KIND_TICK,       10'd0,   1'b1, '{4'h0, 16'd0, 16'd0,    1'b0, 1'b0}},
    '{KIND_RSVD_6,     10'h3FF, 1'b1, '{4'h0, 16'd0, 16'd0,    1'b0, 1'b0}},
    '{KIND_RSVD_7,     10'd0,   1'b1, '{4'h0, 16'd0, 16'd0,    1'b0, 1'b0}},
    '{KIND_LEFT,       10'd0,   1'b1, '{4'h0, 16'd0, 16'd0,    1'b0, 1'b1}},
    '{KIND_RIGHT,      10'd0,   1'b1, '{4'h8, 16'd1, 16'd1000, 1'b1, 1'b0}},
    '{KIND_SET_TARGET, 10'h3FF, 1'b1, '{4'h8, 16'd1, 16'd1023, 1'b1, 1'b0}},
    '{KIND_TICK,       10'd0,   1'b0, NO_CHECK},
    '{KIND_TICK,       10'h3FF, 1'b0, NO_CHECK},
    '{KIND_SET_TARGET, 10'h2AA, 1'b0, NO_CHECK},
    '{KIND_SET_TARGET, 10'h155, 1'b0, NO_CHECK},
    '{KIND_TICK,       10'd0,   1'b0, NO_CHECK},
    '{KIND_LEFT,       10'd0,   1'b0, NO_CHECK},
    '{KIND_TICK,       10'd0,   1'b0, NO_CHECK},
    '{KIND_RIGHT,      10'd0,   1'b0, NO_CHECK},
    '{KIND_STOP,       10'd0,   1'b0, NO_CHECK},
    '{KIND_SET_TARGET, 10'd2,   1'b0, NO_CHECK},
    '{KIND_TICK,       10'd0,   1'b0, NO_CHECK},
    '{KIND_TICK,       10'd0,   1'b0, NO_CHECK},
    '{KIND_TICK,       10'd0,   1'b0, NO_CHECK},
    '{KIND_SET_TARGET, 10'd0,   1'b0, NO_CHECK},
    '{KIND_TICK,       10'd0,   1'b0, NO_CHECK},
    '{KIND_TICK,       10'd0,   1'b0, NO_CHECK},
    '{KIND_TICK,       10'd0,   1'b0, NO_CHECK},
    '{KIND_CALIBRATE,  10'd0,   1'b0, NO_CHECK},
    '{KIND_TICK,       10'd0,   1'b0, NO_CHECK}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic [KIND_W-1:0] in_kind;
  logic [TGT_W-1:0] in_new_target;
  logic out_valid;
  logic out_stall;
  logic [COIL_W-1:0] out_coil_drive;
  logic [POS_W-1:0] out_position_now;
  logic [POS_W-1:0] out_target_now;
  logic out_is_running;
  logic out_turning_ccw;

  // predicted motor state and register copies
  logic [POS_W-1:0]   m_pos;
  logic [POS_W-1:0]   m_goal;
  logic [PHASE_W-1:0] m_phase;
  logic               m_run;
  logic               m_ccw;
  logic [COIL_W-1:0]  m_coils;
  logic [POS_W-1:0]   m_inc;
  logic [POS_W-1:0]   m_max;
  logic [POS_W-1:0]   m_peak;

  motor_res_t  motor_expect_q[$];
  int unsigned items_in     = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned settings     = 0;
  int unsigned hold_left    = 0;
  bit          quiet        = 1'b0;

  always #5 clk = ~clk;

  stepper_target_position_controller_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_new_target    (in_new_target),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_coil_drive   (out_coil_drive),
    .out_position_now (out_position_now),
    .out_target_now   (out_target_now),
    .out_is_running   (out_is_running),
    .out_turning_ccw  (out_turning_ccw)
  );

  // idle length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // one full step: energize the current phase, then advance phase and position
  function automatic void full_step(input logic ccw);
    m_coils = 4'b0001 << m_phase;
    if (!ccw) begin
      m_phase = m_phase + 2'd1;
      if (m_pos != POS_TOP) m_pos = m_pos + 16'd1;
    end else begin
      m_phase = m_phase - 2'd1;
      if (m_pos != '0) m_pos = m_pos - 16'd1;
    end
    if (m_pos > m_peak) m_peak = m_pos;
  endfunction

  // motor state after one item
  function automatic motor_res_t advance_motor(input logic [KIND_W-1:0] kind,
                                               input logic [TGT_W-1:0] tgt);
    logic [POS_W:0] sum;
    case (kind)
      KIND_TICK: begin
        // steer toward the goal, stop at goal or at either limit
        if (m_run) begin
          if (m_pos < m_goal) m_ccw = 1'b0;
          if (m_pos > m_goal) m_ccw = 1'b1;
          if (m_pos == m_goal) begin
            m_run   = 1'b0;
            m_coils = '0;
          end
          if (m_pos == '0 || m_pos >= m_max) m_run = 1'b0;
        end
        if (m_run) full_step(m_ccw);
      end
      KIND_RIGHT: begin
        m_ccw = 1'b0;
        m_run = 1'b1;
        full_step(1'b0);
        sum    = {1'b0, m_goal} + {1'b0, m_inc};
        m_goal = sum[POS_W] ? POS_TOP : sum[POS_W-1:0];
      end
      KIND_LEFT: begin
        m_ccw = 1'b1;
        m_run = 1'b1;
        full_step(1'b1);
        // goal would go negative: settle where the step left us
        if (m_goal >= m_inc) begin
          m_goal = m_goal - m_inc;
        end else begin
          m_goal  = m_pos;
          m_run   = 1'b0;
          m_coils = '0;
        end
      end
      KIND_STOP: begin
        m_run   = 1'b0;
        m_goal  = m_pos;
        m_coils = '0;
      end
      KIND_CALIBRATE: begin
        m_pos  = '0;
        m_goal = '0;
      end
      KIND_SET_TARGET: begin
        m_run  = 1'b1;
        m_goal = {{(POS_W-TGT_W){1'b0}}, tgt};
      end
      default: begin
      end
    endcase
    return '{m_coils, m_pos, m_goal, m_run, m_ccw};
  endfunction

  // offer one item, predict at the transfer, then idle a while
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [TGT_W-1:0] tgt,
                           input logic typed, input motor_res_t typed_res);
    motor_res_t r;
    int unsigned gap;
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_new_target <= tgt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = advance_motor(kind, tgt);
    motor_expect_q.push_back(typed ? typed_res : r);
    items_in++;
    @(negedge clk);
    gap = quiet ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send(input logic [KIND_W-1:0] kind, input logic [TGT_W-1:0] tgt);
    send_item(kind, tgt, 1'b0, NO_CHECK);
  endtask

  // drop valid and wait until every expected result has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (motor_expect_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // write both registers while idle
  task automatic program_regs(input logic [POS_W-1:0] inc, input logic [POS_W-1:0] maxp);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TARGET_INCREMENT;
    cfg_wdata <= inc;
    @(negedge clk);
    cfg_index <= CFG_MAX_POSITION;
    cfg_wdata <= maxp;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    m_inc = inc;
    m_max = maxp;
    settings++;
  endtask

  // goal near the position, within the limit, anywhere, or a bit pattern
  function automatic logic [TGT_W-1:0] pick_target();
    int unsigned lo;
    int unsigned hi;
    case ($urandom_range(0, 3))
      0: return TGT_W'($urandom_range(0, 1023));
      1: begin
        if (m_pos > 16'd1023) return TGT_W'($urandom_range(0, 1023));
        lo = (m_pos > 16'd12) ? m_pos - 12 : 0;
        hi = (m_pos + 12 > 1023) ? 1023 : m_pos + 12;
        return TGT_W'($urandom_range(lo, hi));
      end
      2: return TGT_W'($urandom_range(0, (m_max > 16'd1023) ? 1023 : m_max));
      default: begin
        case ($urandom_range(0, 3))
          0: return 10'h000;
          1: return 10'h3FF;
          2: return 10'h2AA;
          default: return 10'h155;
        endcase
      end
    endcase
  endfunction

  // mostly well-formed moves (kick off, aim, tick along), the rest loose commands
  task automatic random_burst();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      if (m_pos == '0 || $urandom_range(0, 3) == 0)
        send($urandom_range(0, 1) ? KIND_RIGHT : KIND_LEFT, TGT_W'($urandom_range(0, 1023)));
      send(KIND_SET_TARGET, pick_target());
      n = $urandom_range(1, 40);
      repeat (n) send(KIND_TICK, TGT_W'($urandom_range(0, 1023)));
    end else if (r < 62) begin
      send($urandom_range(0, 1) ? KIND_RIGHT : KIND_LEFT, TGT_W'($urandom_range(0, 1023)));
      n = $urandom_range(0, 15);
      repeat (n) send(KIND_TICK, TGT_W'($urandom_range(0, 1023)));
    end else if (r < 70) begin
      send(KIND_STOP, TGT_W'($urandom_range(0, 1023)));
    end else if (r < 76) begin
      send(KIND_CALIBRATE, TGT_W'($urandom_range(0, 1023)));
    end else if (r < 82) begin
      send(KIND_W'($urandom_range(0, 7)), TGT_W'($urandom_range(0, 1023)));
    end else begin
      send(KIND_TICK, TGT_W'($urandom_range(0, 1023)));
    end
  endtask

  // result side: random stalls, plus one long hold on request
  initial begin : result_stall
    int unsigned stall_left;
    int unsigned run_left;
    stall_left = 0;
    run_left   = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (run_left != 0) begin
          run_left--;
        end else begin
          run_left   = $urandom_range(0, 6);
          stall_left = quiet ? 0 : pick_gap();
        end
      end
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin : result_check
    motor_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (motor_expect_q.size() == 0) begin
        $error("result transfer with nothing expected");
        mismatches++;
      end else begin
        want = motor_expect_q.pop_front();
        results_seen++;
        if (out_coil_drive !== want.coil) begin
          $error("coil_drive: expected %0h actual %0h", want.coil, out_coil_drive);
          mismatches++;
        end
        if (out_position_now !== want.pos) begin
          $error("position_now: expected %0d actual %0d", want.pos, out_position_now);
          mismatches++;
        end
        if (out_target_now !== want.tgt) begin
          $error("target_now: expected %0d actual %0d", want.tgt, out_target_now);
          mismatches++;
        end
        if (out_is_running !== want.run) begin
          $error("is_running: expected %0b actual %0b", want.run, out_is_running);
          mismatches++;
        end
        if (out_turning_ccw !== want.ccw) begin
          $error("turning_ccw: expected %0b actual %0b", want.ccw, out_turning_ccw);
          mismatches++;
        end
      end
    end
  end

  // main sequence
  initial begin : stimulus
    logic [POS_W-1:0] phase_inc [0:PHASES-1];
    logic [POS_W-1:0] phase_max [0:PHASES-1];
    int unsigned stop_at;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_TARGET_INCREMENT;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_kind       = KIND_TICK;
    in_new_target = '0;
    m_pos   = '0;
    m_goal  = '0;
    m_phase = '0;
    m_run   = 1'b0;
    m_ccw   = 1'b0;
    m_coils = '0;
    m_peak  = '0;
    m_inc   = TARGET_INCREMENT_RST;
    m_max   = MAX_POSITION_RST;
    phase_inc = '{16'd1, 16'hFFFF, 16'd3, 16'($urandom_range(1, 200)),
                  16'($urandom_range(1, 65535)), 16'd7};
    phase_max = '{16'd1, 16'hFFFF, 16'd40, 16'($urandom_range(20, 600)),
                  16'($urandom_range(1, 65535)), 16'd1000};
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part under the reset register values
    for (int i = 0; i < $size(DIRECTED_PLAN); i++)
      send_item(DIRECTED_PLAN[i].kind, DIRECTED_PLAN[i].tgt,
                DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].res);

    // random phases, one register setting each
    for (int p = 0; p < PHASES; p++) begin
      settle();
      program_regs(phase_inc[p], phase_max[p]);
      quiet = (p == 2);
      if (p == 0) hold_left = HOLD_CYCLES;
      stop_at = items_in + PHASE_ITEMS;
      while (items_in < stop_at) random_burst();
    end

    // goal saturation at the top of the range, back to back
    settle();
    program_regs(16'hFFFF, 16'hFFFF);
    quiet = 1'b1;
    send(KIND_CALIBRATE, 10'd0);
    send(KIND_RIGHT, 10'd0);
    send(KIND_RIGHT, 10'd0);
    repeat (16) send(KIND_TICK, 10'd0);
    send(KIND_RIGHT, 10'd0);
    send(KIND_LEFT, 10'd0);
    send(KIND_SET_TARGET, 10'h3FF);
    quiet = 1'b0;

    settle();
    repeat (8) @(negedge clk);
    $display("covered %0d item transfers and %0d results over %0d register settings",
             items_in, results_seen, settings);
    $display("highest position reached %0d, mismatching fields %0d", m_peak, mismatches);
    if (mismatches == 0 && motor_expect_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
